@@ rtl/core/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: command codes,
// field widths, reset and miss values, and the request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   // Default number of entry slots.
   localparam int ENTRIES_DEF = 16;

   // Field widths.
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Value returned by a get that misses.
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   // Operation codes.
   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   // One request as it travels from the input register to the store.
   typedef struct packed {
      cmd_type           cmd;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] data;
   } req_type;

endpackage

`default_nettype wire

@@ rtl/core/lkv_store.sv @@
// ----------------------------------------------------------------------------
// lkv_store
// Entry array of the cache: parallel key match, recency ages, victim and
// free-slot selection, and the state update for one request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_store
   import lkv_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   input  wire req_type           op,
   input  wire logic [CAP_W-1:0]  capacity,
   output logic                   rsp_hit,
   output logic [DATA_W-1:0]      rsp_data
);

   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Entry state. Keys, values and ages hold meaning only where valid.
   logic [DATA_W-1:0] key_ff   [ENTRIES];
   logic [DATA_W-1:0] value_ff [ENTRIES];
   logic [AGE_W-1:0]  age_ff   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]   count_ff;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   logic [ENTRIES-1:0] free_sel;
   logic [ENTRIES-1:0] sel;
   logic               hit;
   logic [DATA_W-1:0]  hit_value;
   logic [AGE_W-1:0]   hit_age;
   logic [AGE_W-1:0]   oldest_age;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               full;
   logic               is_put;
   logic               touch;
   logic               bump_all;
   logic               write_key;
   logic               write_value;
   logic               insert;

   // Parallel key compare and one-hot readout of the matching entry.
   always_comb begin
      hit_value = '0;
      hit_age   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == op.key);
         if (match[i]) begin
            hit_value = hit_value | value_ff[i];
            hit_age   = hit_age | age_ff[i];
         end
      end
      hit = |match;
   end

   // The least recent entry carries age count-1, since valid ages form a
   // permutation of 0..count-1. The lowest free slot takes a new key.
   assign oldest_age = AGE_W'(count_ff - CNT_W'(1));

   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i]   = valid_ff[i] && (age_ff[i] == oldest_age);
         free_sel[i] = !valid_ff[i] && !seen;
         seen        = seen || !valid_ff[i];
      end
   end

   // Effective capacity: zero counts as one, large values saturate.
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      full = CMP_W'(count_ff) >= eff_cap;
   end

   // Decide which slot is touched and how the others age.
   always_comb begin
      is_put      = (op.cmd == CMD_PUT);
      touch       = 1'b0;
      sel         = '0;
      bump_all    = 1'b0;
      write_key   = 1'b0;
      write_value = 1'b0;
      insert      = 1'b0;
      if (op_valid) begin
         if (hit) begin
            touch       = 1'b1;
            sel         = match;
            write_value = is_put;
         end else if (is_put) begin
            touch       = 1'b1;
            bump_all    = 1'b1;
            write_key   = 1'b1;
            write_value = 1'b1;
            if (full) begin
               sel = victim;
            end else begin
               sel    = free_sel;
               insert = 1'b1;
            end
         end
      end
   end

   // Result of this request.
   assign rsp_hit  = hit;
   assign rsp_data = is_put ? op.data : (hit ? hit_value : MISS_VALUE);

   // Key, value and age update.
   always_ff @(posedge clock) begin
      if (touch) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
               age_ff[i] <= '0;
               if (write_key) begin
                  key_ff[i] <= op.key;
               end
               if (write_value) begin
                  value_ff[i] <= op.data;
               end
            end else if (valid_ff[i] && (bump_all || (age_ff[i] < hit_age))) begin
               age_ff[i] <= age_ff[i] + AGE_W'(1);
            end
         end
      end
   end

   // Valid marks and entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (insert) begin
         valid_ff <= valid_ff | sel;
         count_ff <= count_ff + CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                                Moves
//   req       in         req_valid/ready, cmd, key, data_in   one get or put request
//   rsp       out        rsp_valid/ready, hit, data_out       one response per request
//   csr       in         csr_write_en, csr_write_data         capacity register
//
// A request is taken into an input register; the store then matches all keys in
// parallel, updates the ages, and loads the response register. One request per
// cycle is sustained while the response side is not held off.
// The response register frees the input side; the pipe stalls only when the
// response waits and the input register is full. Reset clears the valid
// marks, the entry count and the capacity (to 16).
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_cmd,
   input  wire logic signed [DATA_W-1:0] req_key,
   input  wire logic signed [DATA_W-1:0] req_data_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_hit,
   output logic signed [DATA_W-1:0]      rsp_data_out,
   input  wire logic                     csr_write_en,
   input  wire logic [CAP_W-1:0]         csr_write_data
);

   logic [CAP_W-1:0]  cap_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   req_type           s1_op_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              advance;
   logic              store_hit;
   logic [DATA_W-1:0] store_data;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write_en) begin
         cap_ff <= csr_write_data;
      end
   end

   // The held request moves on when the response register is free or drains.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign s1_valid_in  = req_valid || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff.cmd  <= cmd_type'(req_cmd);
         s1_op_ff.key  <= $unsigned(req_key);
         s1_op_ff.data <= $unsigned(req_data_in);
      end
   end

   // Entry array and lookup.
   lkv_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op_valid (advance),
      .op       (s1_op_ff),
      .capacity (cap_ff),
      .rsp_hit  (store_hit),
      .rsp_data (store_data)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff  <= store_hit;
         rsp_data_ff <= store_data;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_data_out = $signed(rsp_data_ff);

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key-value cache. A shadow copy of the
// store (keys, values, valid marks, recency ages and capacity) predicts the
// response to every accepted request. Responses are checked in order. Traffic
// covers field extremes, small and saturated capacities, a capacity lowered
// below the stored count, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import lkv_pkg::*;
;

   localparam int SLOTS       = ENTRIES_DEF;
   localparam int DRAIN_PAUSE = 6;
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      logic              hit;
      logic [DATA_W-1:0] data;
   } lookup_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_cmd = 1'b0;
   logic signed [DATA_W-1:0] req_key = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic                     csr_write_en = 1'b0;
   logic [CAP_W-1:0]         csr_write_data = '0;

   // Shadow copy of the cache contents.
   logic [DATA_W-1:0] shadow_key[SLOTS];
   logic [DATA_W-1:0] shadow_value[SLOTS];
   logic              shadow_valid[SLOTS];
   int unsigned       shadow_age[SLOTS];
   logic [CAP_W-1:0]  shadow_capacity;

   lookup_result_type pending_results[$];
   logic [DATA_W-1:0] key_pool[32];
   int                errors = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   lru_key_value_cache #(.ENTRIES(SLOTS)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_data_out   (rsp_data_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Make a slot the most recent; valid entries younger than the limit age by one.
   function automatic void make_recent(input int slot, input int unsigned limit);
      for (int i = 0; i < SLOTS; i++) begin
         if (i != slot && shadow_valid[i] && shadow_age[i] < limit) begin
            shadow_age[i] = shadow_age[i] + 1;
         end
      end
      shadow_age[slot] = 0;
   endfunction

   // Apply one request to the shadow store and return the response it gives.
   function automatic lookup_result_type apply_request(input cmd_type cmd,
                                                       input logic [DATA_W-1:0] key,
                                                       input logic [DATA_W-1:0] data);
      lookup_result_type res;
      int                slot;
      int                free_slot;
      int                victim;
      int unsigned       count;
      int unsigned       oldest;
      int unsigned       room;
      slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) begin
            slot = i;
         end
      end
      if (cmd == CMD_GET) begin
         if (slot >= 0) begin
            res.hit  = 1'b1;
            res.data = shadow_value[slot];
            make_recent(slot, shadow_age[slot]);
         end else begin
            res.hit  = 1'b0;
            res.data = MISS_VALUE;
         end
         return res;
      end
      res.hit  = (slot >= 0);
      res.data = data;
      if (slot >= 0) begin
         shadow_value[slot] = data;
         make_recent(slot, shadow_age[slot]);
         return res;
      end
      // New key: find the free slot and the least recent entry.
      count     = 0;
      free_slot = -1;
      victim    = -1;
      oldest    = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_valid[i]) begin
            count++;
            if (victim < 0 || shadow_age[i] > oldest) begin
               victim = i;
               oldest = shadow_age[i];
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      room = (shadow_capacity == 0) ? 1 : shadow_capacity;
      if (room > SLOTS) begin
         room = SLOTS;
      end
      if (count >= room && victim >= 0) begin
         shadow_key[victim]   = key;
         shadow_value[victim] = data;
         make_recent(victim, oldest);
      end else if (free_slot >= 0) begin
         shadow_valid[free_slot] = 1'b1;
         shadow_key[free_slot]   = key;
         shadow_value[free_slot] = data;
         make_recent(free_slot, SLOTS);
      end
      return res;
   endfunction

   // Offer one request, wait for it to be taken, and record its response.
   task automatic send_request(input cmd_type cmd, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] data);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_key     <= key;
      req_data_in <= data;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_results.push_back(apply_request(cmd, key, data));
   endtask

   // Stop offering and wait until every response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      shadow_capacity = value;
      csr_write_en   <= 1'b0;
   endtask

   // Extreme keys and values, a stored value equal to the miss code, update.
   task automatic test_field_extremes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'hFFFF_FFFF, 32'h5555_5555);
      send_request(CMD_PUT, 32'h8000_0000, 32'h0000_1234);
      send_request(CMD_GET, 32'h8000_0000, 32'hAAAA_AAAA);
      send_request(CMD_GET, 32'h0000_0001, 32'hFFFF_FFFF);
   endtask

   // Capacity zero acts as one while more entries are stored than that.
   task automatic test_small_capacity();
      set_capacity(5'd0);
      send_request(CMD_PUT, 32'h0000_0005, 32'h0000_0050);
      send_request(CMD_GET, 32'h0000_0005, 32'h0000_0000);
      send_request(CMD_PUT, 32'h0000_0006, 32'h0000_0060);
      send_request(CMD_GET, 32'h0000_0005, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0006, 32'h0000_0000);
      send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_PUT, 32'h0000_0006, 32'h0000_0061);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
   endtask

   // Random gets and puts, mostly on a small set of keys so that hits and
   // evictions are frequent.
   task automatic test_random_traffic(input logic [CAP_W-1:0] capacity, input int send_pct,
                                      input int stall_pct, input int count, input int span);
      logic [DATA_W-1:0] key;
      cmd_type           cmd;
      set_capacity(capacity);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(span - 1)] : $urandom();
         cmd = $urandom_range(1) ? CMD_PUT : CMD_GET;
         send_request(cmd, key, $urandom());
      end
   endtask

   // Hold the output off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      set_capacity(5'd1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left     = LONG_HOLD;
      for (int n = 0; n < 100; n++) begin
         send_request($urandom_range(1) ? CMD_PUT : CMD_GET,
                      key_pool[$urandom_range(3)], $urandom());
      end
   endtask

   // Receiver: random stalls, or a long hold when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: response with nothing expected: hit=%0b data_out=%h",
                        $time, rsp_hit, rsp_data_out);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("%0t: hit mismatch: expected %0b, actual %0b",
                           $time, want.hit, rsp_hit);
               end
            end
            if (rsp_data_out !== want.data) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("%0t: data_out mismatch: expected %h, actual %h",
                           $time, want.data, rsp_data_out);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("[lru_key_value_cache] ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_age[i]   = 0;
      end
      shadow_capacity = CAP_RESET;
      foreach (key_pool[i]) begin
         key_pool[i] = $urandom();
      end
      key_pool[1] = 32'h8000_0000;
      key_pool[5] = 32'hFFFF_FFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_small_capacity();
      test_random_traffic(5'd16, 0, 0, 120, 20);
      test_random_traffic(5'd31, 46, 0, 110, 24);
      // Lowered below the stored count: evictions keep the count.
      test_random_traffic(5'd3, 0, 46, 110, 6);
      test_random_traffic(5'd0, 26, 26, 100, 3);
      test_backpressure();
      test_random_traffic(5'd9, 26, 26, 110, 12);

      drain();
      if (errors == 0 && pending_results.size() == 0) begin
         $display("[lru_key_value_cache] OK");
      end else begin
         $display("[lru_key_value_cache] ERROR");
      end
      $finish;
   end

endmodule

@@ lru_key_value_cache.f @@
rtl/core/lkv_pkg.sv
rtl/core/lkv_store.sv
rtl/core/lru_key_value_cache.sv
tb/sv/tb_top.sv
